// File: rtl/mergeable_bloom_filter_core_defines.svh
// assertion macros for the bloom filter core
// used by the top level only, needs clk and rst in scope
`ifndef MERGEABLE_BLOOM_FILTER_CORE_DEFINES_SVH
`define MERGEABLE_BLOOM_FILTER_CORE_DEFINES_SVH

// same-cycle implication checked on every clock edge out of reset
`define MBF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bloom filter core check failed");

// next-cycle implication checked on every clock edge out of reset
`define MBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bloom filter core check failed");

`endif

// File: rtl/mbf_pkg.sv
// shared constants and op codes for the bloom filter core
// no dependencies
package mbf_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int WORD_W    = 64;
  localparam int WORD_AW   = $clog2(MAX_WORDS);
  localparam int BIT_AW    = $clog2(WORD_W);
  localparam int POS_W     = WORD_AW + BIT_AW;      // bit position in the store
  localparam int DIV_W     = POS_W + 1;             // bit count, up to MAX_WORDS*64
  localparam int HASH_W    = 32;
  localparam int ROT_RIGHT = 17;
  localparam int ROT_LEFT  = 15;
  localparam int BYTES_W   = 14;
  localparam int PROBES_W  = 5;
  localparam int PROBE_LIMIT = 30;
  localparam int CAP_BYTES = MAX_WORDS * 8;

  // modulo unit retires this many dividend bits per cycle
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS = HASH_W / MOD_BITS_PER_STEP;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  localparam logic REG_FILTER_BYTES = 1'b0;
  localparam logic REG_NUM_PROBES   = 1'b1;

  localparam logic [BYTES_W-1:0]  FILTER_BYTES_RESET = BYTES_W'(8192);
  localparam logic [PROBES_W-1:0] NUM_PROBES_RESET   = PROBES_W'(6);

endpackage

// File: rtl/mbf_mod.sv
// iterative remainder unit: dividend mod divisor, MOD_BITS_PER_STEP bits per cycle
// depends on mbf_pkg
module mbf_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mbf_pkg::HASH_W-1:0]  dividend,
  input  logic [mbf_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [mbf_pkg::POS_W-1:0]   rem
);
  import mbf_pkg::*;

  logic                  busy;
  logic [MOD_CNT_W-1:0]  cnt;
  logic [HASH_W-1:0]     quo;
  logic [DIV_W-1:0]      dv;
  logic [POS_W-1:0]      r;
  logic [POS_W-1:0]      r_next;

  // restoring steps, remainder stays below the divisor
  always_comb begin
    logic [DIV_W-1:0] t;
    logic [POS_W-1:0] rr;
    rr = r;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      t = {rr, quo[HASH_W-1-i]};
      if (t >= dv) begin
        rr = POS_W'(t - dv);
      end else begin
        rr = t[POS_W-1:0];
      end
    end
    r_next = rr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dv  <= divisor;
      r   <= '0;
    end else if (busy) begin
      quo <= quo << MOD_BITS_PER_STEP;
      r   <= r_next;
    end
  end

  assign rem = r;

endmodule

// File: rtl/mergeable_bloom_filter_core.sv
// top level of the mergeable bloom filter core: bit store memory, probe sequencer
// depends on mbf_pkg, mbf_mod and mergeable_bloom_filter_core_defines.svh
//
// usage
//   s_axis carries one operation per transfer: insert a key hash, query a key
//   hash, or merge one 64-bit word of another filter (OR into the store).
//   m_axis returns exactly one transfer per operation; may_match is the query
//   answer and 0 for insert, merge and unknown ops.
//   cfg_we/cfg_index/cfg_data write filter_bytes (index 0) and num_probes
//   (index 1); write them only while no operation is in flight.
// timing
//   one operation at a time. each insert or query probe runs the remainder unit
//   at 4 hash bits per cycle, then a memory read and a read-modify-write or
//   test; the default is six probes. a query stops at the first clear bit.
//   merge reads the word, then writes it back ORed with the merge data; the
//   remainder unit sets the pace.
// reset
//   rst is synchronous. afterwards all 1024 words of the store are swept to
//   zero, one word per cycle; s_axis_tready stays low until the sweep ends.
// stalls
//   the answer sits in an output register; a new operation is accepted while
//   it waits, and that operation holds in its last cycle until m_axis drains.
`include "mergeable_bloom_filter_core_defines.svh"

module mergeable_bloom_filter_core (
  input  logic                         clk,
  input  logic                         rst,
  // config write port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mbf_pkg::BYTES_W-1:0]  cfg_data,
  // operation input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [111:0]                 s_axis_tdata,  // key_hash[31:0], word_index[41:32],
                                                      // merge_data[105:42], zero pad
  input  logic [1:0]                   s_axis_tuser,  // op[1:0]
  // result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata   // may_match[0], zero pad
);
  import mbf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_MRD   = 3'd4;
  localparam logic [2:0] ST_MWR   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // config registers
  logic [BYTES_W-1:0]  filter_bytes;
  logic [PROBES_W-1:0] num_probes;

  // input fields
  logic [1:0]          in_op;
  logic [HASH_W-1:0]   in_hash;
  logic [WORD_AW-1:0]  in_index;
  logic [WORD_W-1:0]   in_data;

  // control and operation registers
  logic [2:0]          state;
  logic [WORD_AW-1:0]  clr_cnt;
  logic [1:0]          op_q;
  logic [HASH_W-1:0]   h_q;
  logic [HASH_W-1:0]   delta_q;
  logic [HASH_W-1:0]   h_next;
  logic [PROBES_W-1:0] probes_left;
  logic                match_q;
  logic [WORD_AW-1:0]  addr_q;
  logic [BIT_AW-1:0]   bit_q;
  logic [WORD_W-1:0]   data_q;
  logic                out_valid;
  logic                out_match;

  // derived config
  logic [BYTES_W-1:0]  used_bytes;
  logic [DIV_W-1:0]    used_bits;
  logic [PROBES_W-1:0] used_probes;

  // store memory, registered read
  logic [WORD_W-1:0]   store_mem [MAX_WORDS];
  logic                mem_re;
  logic [WORD_AW-1:0]  mem_raddr;
  logic [WORD_W-1:0]   mem_rdata;
  logic                mem_we;
  logic [WORD_AW-1:0]  mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // remainder unit
  logic                mod_start;
  logic [HASH_W-1:0]   mod_dividend;
  logic                mod_done;
  logic [POS_W-1:0]    mod_rem;

  logic                in_xfer;
  logic                out_xfer;
  logic                probe_bit;
  logic                start_probes;

  assign in_op    = s_axis_tuser;
  assign in_hash  = s_axis_tdata[31:0];
  assign in_index = s_axis_tdata[41:32];
  assign in_data  = s_axis_tdata[105:42];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_match};
  assign out_xfer      = out_valid && m_axis_tready;

  // filter size saturates at the store size, probe count at the limit
  assign used_bytes  = (filter_bytes > BYTES_W'(CAP_BYTES)) ? BYTES_W'(CAP_BYTES)
                                                            : filter_bytes;
  assign used_bits   = DIV_W'({used_bytes, 3'b000});
  assign used_probes = (num_probes > PROBES_W'(PROBE_LIMIT)) ? PROBES_W'(PROBE_LIMIT)
                                                             : num_probes;

  assign h_next    = h_q + delta_q;
  assign probe_bit = mem_rdata[bit_q];

  // an insert needs a nonempty filter, a query at least two bytes; both need probes
  always_comb begin
    start_probes = 1'b0;
    case (in_op)
      OP_INSERT: start_probes = (used_bytes != '0) && (used_probes != '0);
      OP_QUERY:  start_probes = (used_bytes >= BYTES_W'(2)) && (used_probes != '0);
      default:   start_probes = 1'b0;
    endcase
  end

  // first remainder starts as an operation with probes is accepted, the next right after a probe that does not end it
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = in_hash;
    if (state == ST_IDLE) begin
      mod_start = in_xfer && start_probes;
    end else if (state == ST_CHK) begin
      mod_dividend = h_next;
      mod_start    = (probes_left != PROBES_W'(1)) &&
                     !((op_q == OP_QUERY) && !probe_bit);
    end
  end

  mbf_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (used_bits),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = mem_rdata | data_q;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_MOD: begin
        mem_re    = mod_done;
        mem_raddr = mod_rem[POS_W-1:BIT_AW];
      end
      ST_MRD: begin
        mem_re = 1'b1;
      end
      ST_CHK: begin
        // insert sets the probed bit, query only looks
        mem_we    = (op_q == OP_INSERT);
        mem_wdata = mem_rdata | (WORD_W'(1) << bit_q);
      end
      ST_MWR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= store_mem[mem_raddr];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bytes <= FILTER_BYTES_RESET;
      num_probes   <= NUM_PROBES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_BYTES: filter_bytes <= cfg_data;
        REG_NUM_PROBES:   num_probes   <= cfg_data[PROBES_W-1:0];
        default:          filter_bytes <= filter_bytes;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == WORD_AW'(MAX_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_op == OP_MERGE) begin
              state <= ST_MRD;
            end else if (start_probes) begin
              state <= ST_MOD;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (mod_start) begin
            state <= ST_MOD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_MRD: state <= ST_MWR;
        ST_MWR: state <= ST_FIN;
        ST_FIN: begin
          // hold the answer until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          op_q        <= in_op;
          h_q         <= in_hash;
          delta_q     <= (in_hash >> ROT_RIGHT) | (in_hash << ROT_LEFT);
          probes_left <= used_probes;
          addr_q      <= in_index;
          data_q      <= (in_op == OP_MERGE) ? in_data : '0;
          // query with no probes answers 1, too small a filter answers 0
          match_q     <= (in_op == OP_QUERY) && (used_bytes >= BYTES_W'(2));
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          addr_q <= mod_rem[POS_W-1:BIT_AW];
          bit_q  <= mod_rem[BIT_AW-1:0];
        end
      end
      ST_CHK: begin
        h_q         <= h_next;
        probes_left <= probes_left - 1'b1;
        if ((op_q == OP_QUERY) && !probe_bit) begin
          match_q <= 1'b0;
        end
      end
      ST_FIN: begin
        if (!out_valid || m_axis_tready) begin
          out_match <= match_q;
        end
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

  // checks
  `MBF_ASSERT_IMPL(a_no_accept_in_clear, state == ST_CLEAR, !s_axis_tready)
  `MBF_ASSERT_IMPL(a_mod_done_in_mod, mod_done, state == ST_MOD)
  `MBF_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state != ST_IDLE)
  `MBF_ASSERT_IMPL(a_no_write_when_idle, state == ST_IDLE || state == ST_FIN, !mem_we)

endmodule
